// ===== hdl/spdsq_pkg.sv =====
// ----------------------------------------------------------------------------
// spdsq_pkg
// Shared widths, codes and helpers for the segment pair distance unit.
// ----------------------------------------------------------------------------
package spdsq_pkg;

  // input coordinate width and center offset width
  localparam int IW = 32;
  localparam int PW = IW + 1;

  // dot products and operands of the second multiply level
  localparam int AW  = 65;
  localparam int DW  = 66;
  localparam int MIW = 66;
  localparam int VW  = 2 * MIW;

  // multiplier limb width and pipeline depth
  localparam int LIMB_W  = 32;
  localparam int MUL_LAT = 3;

  // quotient format and divider depth
  localparam int QW      = 18;
  localparam int QSTEPS  = 18;
  localparam int DIV_LAT = QSTEPS + 2;

  // distance datapath
  localparam int DXW    = 51;
  localparam int DDW    = 2 * DXW;
  localparam int OW     = 63;
  localparam int FRAC_W = 32;

  // whole pipeline, input register through output register
  localparam int PIPE_DEPTH = 3 + MUL_LAT + 4 + DIV_LAT + 3 + MUL_LAT + 1;

  localparam logic [IW-1:0] THR_RESET = 32'd4295;
  localparam logic [OW-1:0] DIST_MAX  = {OW{1'b1}};

  localparam logic signed [QW-1:0] Q_ONE  = 18'sd65536;
  localparam logic signed [QW-1:0] Q_MONE = -18'sd65536;

  typedef logic signed [VW-1:0] wide_t;
  typedef logic signed [1:0]    cls_t;

  // side of a quotient against the range [-1, 1]
  localparam cls_t K_NEG  = -2'sd1;
  localparam cls_t K_ZERO = 2'sd0;
  localparam cls_t K_POS  = 2'sd1;

  // n below -dv, above dv, or inside (dv is never negative)
  function automatic cls_t classify(input wide_t n, input wide_t dv);
    wide_t lo;
    wide_t hi;
    cls_t  k;
    lo = n + dv;
    hi = n - dv;
    if (lo[VW-1]) begin
      k = K_NEG;
    end else if (!hi[VW-1] && (hi != '0)) begin
      k = K_POS;
    end else begin
      k = K_ZERO;
    end
    return k;
  endfunction

endpackage

// ===== hdl/spdsq_dly.sv =====
// ----------------------------------------------------------------------------
// spdsq_dly
// Shift line that keeps side data aligned with the pipeline stages.
// ----------------------------------------------------------------------------
module spdsq_dly #(
  parameter int W = 8,
  parameter int N = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] sh_r [N];

  // advance one tap per enabled cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) begin
        sh_r[i] <= '0;
      end
    end else if (en) begin
      sh_r[0] <= din;
      for (int i = 1; i < N; i++) begin
        sh_r[i] <= sh_r[i-1];
      end
    end
  end

  assign dout = sh_r[N-1];

endmodule

// ===== hdl/spdsq_mul.sv =====
// ----------------------------------------------------------------------------
// spdsq_mul
// Signed wide multiplier in three stages: magnitude, limb products, sum.
// ----------------------------------------------------------------------------
module spdsq_mul
  import spdsq_pkg::*;
#(
  parameter int W = 66
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [W-1:0]   a,
  input  logic signed [W-1:0]   b,
  output logic signed [2*W-1:0] p
);

  localparam int NL = (W + LIMB_W - 1) / LIMB_W;
  localparam int MW = NL * LIMB_W;

  logic [W-1:0]          ma;
  logic [W-1:0]          mb;
  logic [MW-1:0]         ma_r;
  logic [MW-1:0]         mb_r;
  logic                  sg1_r;
  logic                  sg2_r;
  logic [2*LIMB_W-1:0]   pp_r [NL][NL];
  logic [2*MW-1:0]       acc;
  logic signed [2*W-1:0] p_nxt;
  logic signed [2*W-1:0] p_r;

  // magnitudes and result sign
  assign ma = a[W-1] ? (~a + W'(1)) : a;
  assign mb = b[W-1] ? (~b + W'(1)) : b;

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r  <= MW'(ma);
      mb_r  <= MW'(mb);
      sg1_r <= a[W-1] ^ b[W-1];
    end
  end

  // limb by limb partial products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NL; i++) begin
        for (int j = 0; j < NL; j++) begin
          pp_r[i][j] <= ma_r[i*LIMB_W +: LIMB_W] * mb_r[j*LIMB_W +: LIMB_W];
        end
      end
      sg2_r <= sg1_r;
    end
  end

  // column sum and sign
  always_comb begin
    acc = '0;
    for (int i = 0; i < NL; i++) begin
      for (int j = 0; j < NL; j++) begin
        acc = acc + ({{(2*MW-2*LIMB_W){1'b0}}, pp_r[i][j]} << ((i + j) * LIMB_W));
      end
    end
    p_nxt = sg2_r ? -$signed(acc[2*W-1:0]) : $signed(acc[2*W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

// ===== hdl/spdsq_div.sv =====
// ----------------------------------------------------------------------------
// spdsq_div
// Pipelined restoring divider giving a Q1.16 quotient, rounded half away.
// ----------------------------------------------------------------------------
module spdsq_div
  import spdsq_pkg::*;
(
  input  logic                 clk,
  input  logic                 en,
  input  wide_t                num,
  input  wide_t                den,
  output logic signed [QW-1:0] quo
);

  localparam int RW = VW + 1;

  logic [VW-1:0]        mag;
  logic [RW-1:0]        rem_r [QSTEPS+1];
  logic [QW-1:0]        quo_r [QSTEPS+1];
  logic [VW-1:0]        dv_r  [QSTEPS+1];
  logic                 neg_r [QSTEPS+1];
  logic                 dz_r  [QSTEPS+1];
  logic [QW:0]          rnd;
  logic [QW-1:0]        qm;
  logic [QW-1:0]        qc;
  logic signed [QW-1:0] q_nxt;
  logic signed [QW-1:0] q_r;

  // magnitude of the numerator
  assign mag = num[VW-1] ? (~num + VW'(1)) : num;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= {1'b0, mag};
      quo_r[0] <= '0;
      dv_r[0]  <= den;
      neg_r[0] <= num[VW-1];
      dz_r[0]  <= (den == '0);
    end
  end

  // one quotient bit per stage, integer bit first
  for (genvar k = 1; k <= QSTEPS; k++) begin : g_step
    logic [RW-1:0] sh;
    logic [RW-1:0] rem_nxt;
    logic          ge;

    always_comb begin
      sh      = (k == 1) ? rem_r[k-1] : {rem_r[k-1][RW-2:0], 1'b0};
      ge      = (sh >= {1'b0, dv_r[k-1]});
      rem_nxt = ge ? (sh - {1'b0, dv_r[k-1]}) : sh;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        quo_r[k] <= {quo_r[k-1][QW-2:0], ge};
        dv_r[k]  <= dv_r[k-1];
        neg_r[k] <= neg_r[k-1];
        dz_r[k]  <= dz_r[k-1];
      end
    end
  end

  // round off the extra bit, limit to one, apply sign; zero for a zero divisor
  always_comb begin
    rnd = {1'b0, quo_r[QSTEPS]} + (QW+1)'(1);
    qm  = rnd[QW:1];
    qc  = (qm > Q_ONE) ? Q_ONE : qm;
    if (dz_r[QSTEPS]) begin
      q_nxt = '0;
    end else if (neg_r[QSTEPS]) begin
      q_nxt = -$signed(qc);
    end else begin
      q_nxt = $signed(qc);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign quo = q_r;

endmodule

// ===== hdl/segment_pair_distance_squared_unit.sv =====
// ----------------------------------------------------------------------------
// segment_pair_distance_squared_unit
// Closest squared distance between two 2D segments and the clamped
// parameters of the closest points.
//
//   channel   direction  handshake              payload
//   in_       input      in_valid / in_ready    two centers, two half-dirs
//   out_      output     out_valid / out_ready  distance, param_a, param_b
//   cfg_      input      cfg_valid / cfg_ready  parallel threshold
//
// One request per cycle while no result is held, over 37 register stages. Most
// of the depth is the 20-stage quotient pipeline and two three-stage
// multipliers in series.
// All stages advance together; a held result stalls the whole pipeline and
// in_ready drops in the same cycle, so nothing is lost or repeated.
// Synchronous active-low reset clears the valid line and loads THR_RESET into the threshold.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module segment_pair_distance_squared_unit
  import spdsq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [IW-1:0]        cfg_parallel_threshold,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [IW-1:0] in_center_a_x,
  input  logic signed [IW-1:0] in_center_a_y,
  input  logic signed [IW-1:0] in_half_dir_a_x,
  input  logic signed [IW-1:0] in_half_dir_a_y,
  input  logic signed [IW-1:0] in_center_b_x,
  input  logic signed [IW-1:0] in_center_b_y,
  input  logic signed [IW-1:0] in_half_dir_b_x,
  input  logic signed [IW-1:0] in_half_dir_b_y,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OW-1:0]        out_distance_squared,
  output logic signed [QW-1:0] out_param_a,
  output logic signed [QW-1:0] out_param_b
);

  logic en;
  logic [IW-1:0] thr_r;

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_valid) begin
      thr_r <= cfg_parallel_threshold;
    end
  end
  assign cfg_ready = 1'b1;

  // global advance
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  spdsq_dly #(.W(1), .N(PIPE_DEPTH)) u_vld (
    .clk(clk), .rst_n(rst_n), .en(en), .din(in_valid), .dout(out_valid)
  );

  // input register and center offset
  logic signed [IW-1:0] ax_r, ay_r, bx_r, by_r;
  logic signed [PW-1:0] px_r, py_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r <= in_half_dir_a_x;
      ay_r <= in_half_dir_a_y;
      bx_r <= in_half_dir_b_x;
      by_r <= in_half_dir_b_y;
      px_r <= PW'(in_center_a_x) - PW'(in_center_b_x);
      py_r <= PW'(in_center_a_y) - PW'(in_center_b_y);
    end
  end

  // coordinate products
  logic signed [2*IW-1:0]  axax_r, ayay_r, axbx_r, ayby_r, bxbx_r, byby_r;
  logic signed [IW+PW-1:0] axpx_r, aypy_r, bxpx_r, bypy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      axax_r <= ax_r * ax_r;
      ayay_r <= ay_r * ay_r;
      axbx_r <= ax_r * bx_r;
      ayby_r <= ay_r * by_r;
      bxbx_r <= bx_r * bx_r;
      byby_r <= by_r * by_r;
      axpx_r <= ax_r * px_r;
      aypy_r <= ay_r * py_r;
      bxpx_r <= bx_r * px_r;
      bypy_r <= by_r * py_r;
    end
  end

  // dot products
  logic signed [AW-1:0] a_r, b_r, c_r;
  logic signed [DW-1:0] d_r, e_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= AW'(axax_r) + AW'(ayay_r);
      b_r <= AW'(axbx_r) + AW'(ayby_r);
      c_r <= AW'(bxbx_r) + AW'(byby_r);
      d_r <= DW'(axpx_r) + DW'(aypy_r);
      e_r <= DW'(bxpx_r) + DW'(bypy_r);
    end
  end

  // second level products
  wide_t ac_p, bb_p, be_p, cd_p, ae_p, bd_p;

  spdsq_mul #(.W(MIW)) u_ac (
    .clk(clk), .en(en), .a(MIW'(a_r)), .b(MIW'(c_r)), .p(ac_p)
  );
  spdsq_mul #(.W(MIW)) u_bb (
    .clk(clk), .en(en), .a(MIW'(b_r)), .b(MIW'(b_r)), .p(bb_p)
  );
  spdsq_mul #(.W(MIW)) u_be (
    .clk(clk), .en(en), .a(MIW'(b_r)), .b(MIW'(e_r)), .p(be_p)
  );
  spdsq_mul #(.W(MIW)) u_cd (
    .clk(clk), .en(en), .a(MIW'(c_r)), .b(MIW'(d_r)), .p(cd_p)
  );
  spdsq_mul #(.W(MIW)) u_ae (
    .clk(clk), .en(en), .a(MIW'(a_r)), .b(MIW'(e_r)), .p(ae_p)
  );
  spdsq_mul #(.W(MIW)) u_bd (
    .clk(clk), .en(en), .a(MIW'(b_r)), .b(MIW'(d_r)), .p(bd_p)
  );

  logic signed [AW-1:0] a7, b7, c7;
  logic signed [DW-1:0] d7, e7;

  spdsq_dly #(.W(3*AW + 2*DW), .N(MUL_LAT + 1)) u_dot_dly (
    .clk(clk), .rst_n(rst_n), .en(en),
    .din({a_r, b_r, c_r, d_r, e_r}),
    .dout({a7, b7, c7, d7, e7})
  );

  // determinant and unclamped numerators
  wide_t det_r, sn0_r, tn0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      det_r <= ac_p - bb_p;
      sn0_r <= be_p - cd_p;
      tn0_r <= ae_p - bd_p;
    end
  end

  // parallel test and first clamp
  logic  par;
  logic  clamp;
  cls_t  ks;
  cls_t  ksel;
  wide_t ep, em;
  wide_t sn8_r, sd8_r, tn8_r, td8_r;
  logic signed [AW-1:0] a8_r, b8_r;
  logic signed [DW-1:0] d8_r;

  always_comb begin
    par   = (det_r == '0) || (det_r < VW'({thr_r, {FRAC_W{1'b0}}}));
    ks    = classify(sn0_r, det_r);
    ksel  = par ? (d7[DW-1] ? K_NEG : K_POS) : ks;
    clamp = par || (ks != K_ZERO);
    ep    = VW'(e7) + VW'(b7);
    em    = VW'(e7) - VW'(b7);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sn8_r <= clamp ? VW'(ksel) : sn0_r;
      sd8_r <= clamp ? VW'(1) : det_r;
      tn8_r <= clamp ? ((ksel == K_NEG) ? em : ep) : tn0_r;
      td8_r <= clamp ? VW'(c7) : det_r;
      a8_r  <= a7;
      b8_r  <= b7;
      d8_r  <= d7;
    end
  end

  // second parameter range check
  cls_t  kt;
  wide_t sp, sm;
  cls_t  kt9_r;
  wide_t sn2_9_r, sn9_r, sd9_r, tn9_r, td9_r;
  logic signed [AW-1:0] a9_r;

  always_comb begin
    kt = (td8_r == '0) ? K_ZERO : classify(tn8_r, td8_r);
    sp = VW'(b8_r) - VW'(d8_r);
    sm = -VW'(b8_r) - VW'(d8_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kt9_r   <= kt;
      sn2_9_r <= (kt == K_NEG) ? sm : sp;
      sn9_r   <= sn8_r;
      sd9_r   <= sd8_r;
      tn9_r   <= tn8_r;
      td9_r   <= td8_r;
      a9_r    <= a8_r;
    end
  end

  // re-solve check and divider operand select
  cls_t  j;
  logic  kt_set;
  cls_t  kt10_r, j10_r;
  wide_t n2_r, d2_r, tn10_r, td10_r;

  always_comb begin
    j      = (a9_r == '0) ? K_ZERO : classify(sn2_9_r, VW'(a9_r));
    kt_set = (kt9_r != K_ZERO);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kt10_r <= kt9_r;
      j10_r  <= j;
      n2_r   <= kt_set ? sn2_9_r : sn9_r;
      d2_r   <= kt_set ? VW'(a9_r) : sd9_r;
      tn10_r <= tn9_r;
      td10_r <= td9_r;
    end
  end

  // quotients
  logic signed [QW-1:0] q1, q2;
  cls_t kt30, j30;

  spdsq_div u_div_t (.clk(clk), .en(en), .num(tn10_r), .den(td10_r), .quo(q1));
  spdsq_div u_div_s (.clk(clk), .en(en), .num(n2_r), .den(d2_r), .quo(q2));

  spdsq_dly #(.W(4), .N(DIV_LAT)) u_cls_dly (
    .clk(clk), .rst_n(rst_n), .en(en),
    .din({kt10_r, j10_r}), .dout({kt30, j30})
  );

  // final parameters
  logic signed [QW-1:0] sq_r, tq_r;

  always_ff @(posedge clk) begin
    if (en) begin
      tq_r <= (kt30 != K_ZERO) ? ((kt30 == K_NEG) ? Q_MONE : Q_ONE) : q1;
      sq_r <= ((kt30 != K_ZERO) && (j30 != K_ZERO)) ?
              ((j30 == K_NEG) ? Q_MONE : Q_ONE) : q2;
    end
  end

  // half-directions and offset held for the distance
  logic signed [IW-1:0] ax31, ay31, bx31, by31;
  logic signed [PW-1:0] px32, py32;

  spdsq_dly #(.W(4*IW), .N(3 + MUL_LAT + 4 + DIV_LAT + 1 - 1)) u_dir_dly (
    .clk(clk), .rst_n(rst_n), .en(en),
    .din({ax_r, ay_r, bx_r, by_r}), .dout({ax31, ay31, bx31, by31})
  );

  spdsq_dly #(.W(2*PW), .N(3 + MUL_LAT + 4 + DIV_LAT + 1)) u_off_dly (
    .clk(clk), .rst_n(rst_n), .en(en),
    .din({px_r, py_r}), .dout({px32, py32})
  );

  // parameter times direction
  logic signed [QW+IW-1:0] psax_r, psay_r, ptbx_r, ptby_r;

  always_ff @(posedge clk) begin
    if (en) begin
      psax_r <= sq_r * ax31;
      psay_r <= sq_r * ay31;
      ptbx_r <= tq_r * bx31;
      ptby_r <= tq_r * by31;
    end
  end

  // difference vector between the closest points
  logic signed [DXW-1:0] dx_r, dy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= (DXW'(px32) <<< 16) + DXW'(psax_r) - DXW'(ptbx_r);
      dy_r <= (DXW'(py32) <<< 16) + DXW'(psay_r) - DXW'(ptby_r);
    end
  end

  // squares
  logic signed [DDW-1:0] dxx_p, dyy_p;

  spdsq_mul #(.W(DXW)) u_dxx (.clk(clk), .en(en), .a(dx_r), .b(dx_r), .p(dxx_p));
  spdsq_mul #(.W(DXW)) u_dyy (.clk(clk), .en(en), .a(dy_r), .b(dy_r), .p(dyy_p));

  logic signed [QW-1:0] sq36, tq36;

  spdsq_dly #(.W(2*QW), .N(2 + MUL_LAT)) u_par_dly (
    .clk(clk), .rst_n(rst_n), .en(en),
    .din({sq_r, tq_r}), .dout({sq36, tq36})
  );

  // output register with saturation
  logic [DDW-1:0] dd;
  logic [OW-1:0]  dist_r;
  logic signed [QW-1:0] pa_r, pb_r;

  assign dd = $unsigned(dxx_p) + $unsigned(dyy_p);

  always_ff @(posedge clk) begin
    if (en) begin
      dist_r <= (|dd[DDW-1:OW+FRAC_W]) ? DIST_MAX : dd[OW+FRAC_W-1:FRAC_W];
      pa_r   <= sq36;
      pb_r   <= tq36;
    end
  end

  assign out_distance_squared = dist_r;
  assign out_param_a          = pa_r;
  assign out_param_b          = pb_r;

endmodule

// ===== sim/tb_segment_pair_distance_squared_unit.sv =====
// ----------------------------------------------------------------------------
// tb_segment_pair_distance_squared_unit
// Streams segment pairs through the distance unit under random idling and
// back-pressure, checks each result against exact wide integer arithmetic or a
// fixed expected value, comparing distance and both parameters, over several threshold settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_segment_pair_distance_squared_unit;
  import spdsq_pkg::*;

  typedef logic signed [199:0] big_t;

  typedef struct {
    logic signed [IW-1:0] cax, cay, hax, hay, cbx, cby, hbx, hby;
  } pair_t;

  typedef struct {
    logic [OW-1:0]        dsq;
    logic signed [QW-1:0] pa;
    logic signed [QW-1:0] pb;
  } closest_t;

  typedef struct {
    pair_t    pr;
    bit       known;
    closest_t res;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [IW-1:0]        cfg_parallel_threshold = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [IW-1:0] in_center_a_x = '0, in_center_a_y = '0;
  logic signed [IW-1:0] in_half_dir_a_x = '0, in_half_dir_a_y = '0;
  logic signed [IW-1:0] in_center_b_x = '0, in_center_b_y = '0;
  logic signed [IW-1:0] in_half_dir_b_x = '0, in_half_dir_b_y = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [OW-1:0]        out_distance_squared;
  logic signed [QW-1:0] out_param_a;
  logic signed [QW-1:0] out_param_b;

  closest_t      pending_q[$];
  logic [IW-1:0] threshold_copy = THR_RESET;
  int            errors = 0;
  bit            sender_calm = 1'b0;
  int unsigned   cycle_cnt = 0;

  segment_pair_distance_squared_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_parallel_threshold(cfg_parallel_threshold),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_center_a_x(in_center_a_x), .in_center_a_y(in_center_a_y),
    .in_half_dir_a_x(in_half_dir_a_x), .in_half_dir_a_y(in_half_dir_a_y),
    .in_center_b_x(in_center_b_x), .in_center_b_y(in_center_b_y),
    .in_half_dir_b_x(in_half_dir_b_x), .in_half_dir_b_y(in_half_dir_b_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_distance_squared(out_distance_squared),
    .out_param_a(out_param_a), .out_param_b(out_param_b)
  );

  // clock
  always #5 clk = ~clk;

  // side of n/dv against [-1, 1]
  function automatic int side_of(big_t n, big_t dv);
    if (n + dv < 0) return -1;
    if (n - dv > 0) return 1;
    return 0;
  endfunction

  // n/dv rounded to q1.16, ties away from zero
  function automatic logic signed [QW-1:0] round_q16(big_t n, big_t dv);
    big_t m;
    big_t x;
    big_t q;
    if (dv == 0) return '0;
    m = (n < 0) ? -n : n;
    x = (m <<< 17) / dv;
    q = (x + 1) >>> 1;
    if (q > 65536) q = 65536;
    return (n < 0) ? -q[QW-1:0] : q[QW-1:0];
  endfunction

  // closest points and squared distance of one segment pair
  function automatic closest_t closest_points(pair_t p, logic [IW-1:0] thr_reg);
    big_t ax, ay, bx, by, px, py;
    big_t a, b, c, d, e, det, thr, sn, sd, tn, td, dx, dy, dd, lim;
    big_t sqb, tqb;
    int k, j;
    closest_t r;
    ax = p.hax; ay = p.hay; bx = p.hbx; by = p.hby;
    px = p.cax; px = px - p.cbx;
    py = p.cay; py = py - p.cby;
    a = ax * ax + ay * ay;
    b = ax * bx + ay * by;
    c = bx * bx + by * by;
    d = ax * px + ay * py;
    e = bx * px + by * py;
    det = a * c - b * b;
    thr = thr_reg;
    thr = thr <<< 32;
    if (det == 0 || det < thr) begin
      // nearly parallel: end of the first segment picked by the sign of d
      sn = (d < 0) ? -1 : 1;
      sd = 1;
      tn = (d < 0) ? e - b : e + b;
      td = c;
    end else begin
      sn = b * e - c * d;
      sd = det;
      k = side_of(sn, det);
      if (k != 0) begin
        sn = k;
        sd = 1;
        tn = (k < 0) ? e - b : e + b;
        td = c;
      end else begin
        tn = a * e - b * d;
        td = det;
      end
    end
    // clamp the second parameter and re-solve the first
    k = (td == 0) ? 0 : side_of(tn, td);
    if (k != 0) begin
      r.pb = (k < 0) ? Q_MONE : Q_ONE;
      sn = (k < 0) ? -b - d : b - d;
      j = (a == 0) ? 0 : side_of(sn, a);
      if (j != 0) r.pa = (j < 0) ? Q_MONE : Q_ONE;
      else r.pa = round_q16(sn, a);
    end else begin
      r.pb = round_q16(tn, td);
      r.pa = round_q16(sn, sd);
    end
    // squared distance of the quantized points
    sqb = r.pa;
    tqb = r.pb;
    dx = px * 65536 + sqb * ax - tqb * bx;
    dy = py * 65536 + sqb * ay - tqb * by;
    dd = dx * dx + dy * dy;
    lim = 1;
    lim = lim <<< 95;
    if (dd >= lim) r.dsq = DIST_MAX;
    else r.dsq = dd[94:32];
    return r;
  endfunction

  // random signed value of the given width, sign extended
  function automatic logic signed [IW-1:0] rnd_w(int w);
    logic signed [IW-1:0] v;
    v = $urandom;
    return v >>> (IW - w);
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    int sel;
    int sh;
    sel = $urandom_range(0, 9);
    p.cax = rnd_w(25); p.cay = rnd_w(25); p.cbx = rnd_w(25); p.cby = rnd_w(25);
    p.hax = rnd_w(21); p.hay = rnd_w(21); p.hbx = rnd_w(21); p.hby = rnd_w(21);
    case (sel)
      0, 1, 2: begin
        p.cax = $urandom; p.cay = $urandom; p.cbx = $urandom; p.cby = $urandom;
        p.hax = $urandom; p.hay = $urandom; p.hbx = $urandom; p.hby = $urandom;
      end
      5: begin
        // parallel or anti-parallel directions
        sh = $urandom_range(0, 3);
        p.hbx = p.hax >>> sh;
        p.hby = p.hay >>> sh;
        if ($urandom_range(0, 1)) begin
          p.hbx = -p.hbx;
          p.hby = -p.hby;
        end
      end
      6: begin
        p.hbx = '0; p.hby = '0;
      end
      7: begin
        p.hax = '0; p.hay = '0;
      end
      8: begin
        // tiny directions, determinant near the threshold
        p.hax = rnd_w(4); p.hay = rnd_w(4); p.hbx = rnd_w(4); p.hby = rnd_w(4);
      end
      9: begin
        // crossing segments with nearby centers
        p.cbx = p.cax + rnd_w(19);
        p.cby = p.cay + rnd_w(19);
      end
      default: ;
    endcase
    return p;
  endfunction

  // offer one request, with random idle cycles before it
  task automatic send_pair(pair_t p, bit known, closest_t fixed);
    while (!sender_calm && $urandom_range(0, 99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_center_a_x <= p.cax; in_center_a_y <= p.cay;
    in_half_dir_a_x <= p.hax; in_half_dir_a_y <= p.hay;
    in_center_b_x <= p.cbx; in_center_b_y <= p.cby;
    in_half_dir_b_x <= p.hbx; in_half_dir_b_y <= p.hby;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (known) pending_q.push_back(fixed);
    else pending_q.push_back(closest_points(p, threshold_copy));
  endtask

  // threshold write, only once the pipeline has drained
  task automatic write_threshold(logic [IW-1:0] v);
    in_valid <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (PIPE_DEPTH + 8) @(posedge clk);
    cfg_parallel_threshold <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    threshold_copy = v;
  endtask

  // receiver: random stalls, one calm window, one long hold-off
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= 1500 && cycle_cnt < 1800) begin
      out_ready <= 1'b0;
    end else if (cycle_cnt >= 2600 && cycle_cnt < 3200) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= 35);
    end
  end

  // result checker
  always @(posedge clk) begin
    closest_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result dist=%h pa=%0d pb=%0d", $time,
                 out_distance_squared, out_param_a, out_param_b);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (out_distance_squared !== want.dsq) begin
          $display("%0t: distance_squared expected %h actual %h", $time,
                   want.dsq, out_distance_squared);
          errors++;
        end
        if (out_param_a !== want.pa) begin
          $display("%0t: param_a expected %0d actual %0d", $time, want.pa, out_param_a);
          errors++;
        end
        if (out_param_b !== want.pb) begin
          $display("%0t: param_b expected %0d actual %0d", $time, want.pb, out_param_b);
          errors++;
        end
      end
    end
  end

  // overall time limit
  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  // stimulus
  initial begin
    row_t           rows[$];
    row_t           rw;
    logic [IW-1:0]  thr_list[5];
    int             n;
    closest_t       none;

    none = '{default: '0};
    thr_list[0] = '0;
    thr_list[1] = 32'hFFFF_FFFF;
    thr_list[2] = 32'd1;
    thr_list[3] = $urandom;
    thr_list[4] = THR_RESET;

    // all zero: degenerate, first parameter at +1
    rw.pr = '{default: '0}; rw.known = 1;
    rw.res = '{dsq: '0, pa: Q_ONE, pb: '0};
    rows.push_back(rw);
    // most negative directions, coincident centers
    rw.pr = '{cax: 0, cay: 0, hax: 32'sh8000_0000, hay: 32'sh8000_0000,
              cbx: 0, cby: 0, hbx: 32'sh8000_0000, hby: 32'sh8000_0000};
    rw.res = '{dsq: '0, pa: Q_ONE, pb: Q_ONE};
    rows.push_back(rw);
    // far apart centers: distance saturates, both parameters clamp
    rw.pr = '{cax: 32'sh7FFF_FFFF, cay: 32'sh7FFF_FFFF, hax: 1, hay: 0,
              cbx: 32'sh8000_0000, cby: 32'sh8000_0000, hbx: 0, hby: 1};
    rw.res = '{dsq: DIST_MAX, pa: Q_MONE, pb: Q_ONE};
    rows.push_back(rw);
    rw.known = 0; rw.res = none;
    // perpendicular crossing, unit halves
    rw.pr = '{cax: 0, cay: 0, hax: 32'sh1_0000, hay: 0,
              cbx: 0, cby: 0, hbx: 0, hby: 32'sh1_0000};
    rows.push_back(rw);
    // parallel with offset, and anti-parallel
    rw.pr = '{cax: 0, cay: 0, hax: 32'sh2_0000, hay: 0,
              cbx: 32'sh1_0000, cby: 32'sh3_0000, hbx: 32'sh1_0000, hby: 0};
    rows.push_back(rw);
    rw.pr.hbx = -32'sh1_0000;
    rows.push_back(rw);
    // zero-length second segment
    rw.pr = '{cax: 32'sh5_0000, cay: -32'sh2_0000, hax: 32'sh1_8000, hay: 32'sh0_4000,
              cbx: 0, cby: 0, hbx: 0, hby: 0};
    rows.push_back(rw);
    // zero-length first segment, second clamps
    rw.pr = '{cax: 32'sh9_0000, cay: 0, hax: 0, hay: 0,
              cbx: 0, cby: 0, hbx: 32'sh1_0000, hby: 32'sh0_1000};
    rows.push_back(rw);
    // extremes of every field
    rw.pr = '{cax: 32'sh7FFF_FFFF, cay: 32'sh8000_0000, hax: 32'sh7FFF_FFFF,
              hay: 32'sh8000_0000, cbx: 32'sh8000_0000, cby: 32'sh7FFF_FFFF,
              hbx: 32'sh8000_0000, hby: 32'sh7FFF_FFFF};
    rows.push_back(rw);
    rw.pr = '{cax: -1, cay: -1, hax: -1, hay: 1, cbx: 1, cby: 1, hbx: 1, hby: -1};
    rows.push_back(rw);
    // skew segments where the first parameter clamps first
    rw.pr = '{cax: 32'sh10_0000, cay: 32'sh1_0000, hax: 32'sh1_0000, hay: 0,
              cbx: 0, cby: 0, hbx: 32'sh1_0000, hby: 32'sh1_0000};
    rows.push_back(rw);
    // tiny directions, determinant below the default threshold
    rw.pr = '{cax: 0, cay: 32'sh0_0100, hax: 3, hay: 1, cbx: 0, cby: 0, hbx: 2, hby: 1};
    rows.push_back(rw);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_pair(rows[i].pr, rows[i].known, rows[i].res);

    // random phases over several thresholds
    n = 0;
    foreach (thr_list[p]) begin
      write_threshold(thr_list[p]);
      repeat (360) begin
        sender_calm = (n >= 600 && n < 800);
        send_pair(random_pair(), 1'b0, none);
        n++;
      end
    end
    in_valid <= 1'b0;

    wait (pending_q.size() == 0);
    repeat (PIPE_DEPTH + 8) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== segment_pair_distance_squared_unit.f =====
hdl/spdsq_pkg.sv
hdl/spdsq_dly.sv
hdl/spdsq_mul.sv
hdl/spdsq_div.sv
hdl/segment_pair_distance_squared_unit.sv
sim/tb_segment_pair_distance_squared_unit.sv
